[hdl/krt_pkg.sv]
// Shared constants, codes and types of the keyed record table.
package krt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int NAME_W   = 64;
    localparam int PHONE_W  = 56;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [NAME_W-1:0]       name;
        logic [PHONE_W-1:0]      phone;
    } rec_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic             set_valid;
        logic             clr_valid;
        logic [IDX_W-1:0] wr_idx;
        rec_t             wr_rec;
    } store_ctl_t;

endpackage

[hdl/krt_req_if.sv]
// Command channel of the keyed record table.
interface krt_req_if import krt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] record_key;
    logic [NAME_W-1:0]       name_text;
    logic [PHONE_W-1:0]      phone_digits;

    modport source (output valid, output command, output record_key,
                    output name_text, output phone_digits, input ready);
    modport sink (input valid, input command, input record_key,
                  input name_text, input phone_digits, output ready);
endinterface

[hdl/krt_rsp_if.sv]
// Result channel of the keyed record table.
interface krt_rsp_if import krt_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] found_key;
    logic [NAME_W-1:0]       found_name;
    logic [PHONE_W-1:0]      found_phone;
    logic                    last;

    modport source (output valid, output status, output slot, output found_key,
                    output found_name, output found_phone, output last,
                    input ready);
    modport sink (input valid, input status, input slot, input found_key,
                  input found_name, input found_phone, input last,
                  output ready);
endinterface

[hdl/krt_store.sv]
// Record memory with registered read port and per-slot valid flags.
module krt_store import krt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  store_ctl_t         ctl,
    output rec_t               rd_rec,
    output logic [ENTRIES-1:0] valid_vec
);

    rec_t               mem [ENTRIES];
    rec_t               rd_rec_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_idx] <= ctl.wr_rec;
        end
        if (ctl.rd_en)
        begin
            rd_rec_reg <= mem[ctl.rd_idx];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.set_valid)
        begin
            valid_next[ctl.wr_idx] = 1'b1;
        end
        if (ctl.clr_valid)
        begin
            valid_next[ctl.wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_rec    = rd_rec_reg;
    assign valid_vec = valid_reg;

endmodule

[hdl/keyed_record_table_top.sv]
// Keyed record table: a sequencer that scans the record memory for each known command.
// The table holds ENTRIES records, each a signed key, a name word and a packed BCD
// phone number, and is empty after reset. A command is taken only while the table
// is idle; it then scans the slots in index order, reading one record per cycle
// through the single read port of the record memory, but not while a finished
// item waits on an output register that still holds an untaken item; a non-LIST
// scan ends early at a key match. Every command except an unused code gives at
// least one item, and the final item of a command has last set. A finished item
// waits in the output register, so the next command may start before it is taken.
module keyed_record_table_top import krt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    krt_req_if.sink   req,
    krt_rsp_if.source rsp
);

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t                  state_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [NAME_W-1:0]       name_reg;
    logic [PHONE_W-1:0]      phone_reg;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    cmp_vld_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;

    logic                    out_vld_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    rec_t                    out_rec_reg;
    logic                    out_last_reg;

    store_ctl_t              ctl;
    rec_t                    rd_rec;
    logic [ENTRIES-1:0]      valid_vec;

    logic                    accept;
    logic                    out_busy;
    logic                    cmp_valid_bit;
    logic                    cmp_hit;
    logic                    cmp_end;
    logic                    tail_empty;
    logic                    free_hit;
    logic [IDX_W-1:0]        free_slot;
    logic                    emit;
    logic                    done;
    logic                    stall;
    logic                    issue;
    logic [STATUS_W-1:0]     em_status;
    logic [IDX_W-1:0]        em_idx;
    rec_t                    em_rec;
    logic                    em_has_rec;
    logic                    em_last;

    krt_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_rec    (rd_rec),
        .valid_vec (valid_vec)
    );

    assign accept   = req.valid && req.ready;
    assign out_busy = out_vld_reg && !rsp.ready;

    assign cmp_valid_bit = valid_vec[cmp_idx_reg];
    assign cmp_hit       = cmp_vld_reg && cmp_valid_bit && (rd_rec.key == key_reg);
    assign cmp_end       = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign tail_empty    = ((valid_vec >> cmp_idx_reg) >> 1) == '0;
    assign free_hit      = free_found_reg || !cmp_valid_bit;
    assign free_slot     = free_found_reg ? free_idx_reg : cmp_idx_reg;

    always_comb
    begin
        emit       = 1'b0;
        done       = 1'b0;
        issue      = 1'b0;
        em_status  = STAT_OK;
        em_idx     = cmp_idx_reg;
        em_rec     = rd_rec;
        em_has_rec = 1'b1;
        em_last    = 1'b1;
        ctl        = '0;

        if (state_reg == S_SCAN && cmp_vld_reg)
        begin
            if (cmd_reg == CMD_LIST)
            begin
                done = cmp_end;
                if (cmp_valid_bit)
                begin
                    emit    = 1'b1;
                    em_last = tail_empty;
                end
                else if (cmp_end && valid_vec == '0)
                begin
                    emit       = 1'b1;
                    em_status  = STAT_MISSING;
                    em_has_rec = 1'b0;
                end
            end
            else if (cmp_hit)
            begin
                emit = 1'b1;
                done = 1'b1;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        em_status = STAT_DUP;
                    end
                    CMD_DELETE:
                    begin
                        ctl.clr_valid = 1'b1;
                        ctl.wr_idx    = cmp_idx_reg;
                    end
                    CMD_UPDATE:
                    begin
                        em_rec.name = name_reg;
                        ctl.wr_en   = 1'b1;
                        ctl.wr_idx  = cmp_idx_reg;
                        ctl.wr_rec  = em_rec;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmp_end)
            begin
                emit = 1'b1;
                done = 1'b1;
                if (cmd_reg == CMD_INSERT && free_hit)
                begin
                    em_idx        = free_slot;
                    em_rec.key    = key_reg;
                    em_rec.name   = name_reg;
                    em_rec.phone  = phone_reg;
                    ctl.wr_en     = 1'b1;
                    ctl.set_valid = 1'b1;
                    ctl.wr_idx    = free_slot;
                    ctl.wr_rec    = em_rec;
                end
                else
                begin
                    em_status  = (cmd_reg == CMD_INSERT) ? STAT_FULL : STAT_MISSING;
                    em_has_rec = 1'b0;
                end
            end
        end

        stall = emit && out_busy;
        if (stall)
        begin
            ctl.wr_en     = 1'b0;
            ctl.set_valid = 1'b0;
            ctl.clr_valid = 1'b0;
            done          = 1'b0;
        end

        if (state_reg == S_SCAN && !stall && !done && rd_idx_reg < CNT_W'(ENTRIES))
        begin
            issue      = 1'b1;
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = rd_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            key_reg        <= '0;
            name_reg       <= '0;
            phone_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            out_vld_reg    <= 1'b0;
            out_status_reg <= '0;
            out_slot_reg   <= '0;
            out_rec_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (emit && !stall)
            begin
                out_vld_reg    <= 1'b1;
                out_status_reg <= em_status;
                out_slot_reg   <= em_has_rec ? SLOT_W'(em_idx) : '0;
                out_rec_reg    <= em_has_rec ? em_rec : '0;
                out_last_reg   <= em_last;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= req.command;
                        key_reg        <= req.record_key;
                        name_reg       <= req.name_text;
                        phone_reg      <= req.phone_digits;
                        rd_idx_reg     <= '0;
                        cmp_vld_reg    <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (req.command <= CMD_LIST)
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (!stall)
                    begin
                        cmp_vld_reg <= issue;
                        if (issue)
                        begin
                            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
                            rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                        end
                        if (cmp_vld_reg && !free_found_reg && !cmp_valid_bit)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                        if (done)
                        begin
                            state_reg   <= S_IDLE;
                            cmp_vld_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.found_key   = out_rec_reg.key;
    assign rsp.found_name  = out_rec_reg.name;
    assign rsp.found_phone = out_rec_reg.phone;
    assign rsp.last        = out_last_reg;

endmodule
